// ----- hw/rtl/spq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types for the sorted priority queue
// Command/response payloads, opcode and status codes, the slot entry type and the cell control broadcast.
// ----------------------------------------------------------------------------
package spq_pkg;

	// Default number of slots in the chain
	localparam int QUEUE_DEPTH_DEF = 16;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	// One held entry
	typedef struct packed {
		logic signed [31:0] value;
		logic signed [15:0] rank;
	} entry_t;

	// Command transaction
	typedef struct packed {
		opcode_t            opcode;
		logic signed [31:0] value;
		logic signed [15:0] rank;
	} cmd_t;

	// Response transaction
	typedef struct packed {
		status_t            status;
		logic signed [31:0] head_value;
		logic signed [15:0] head_rank;
		logic               is_empty;
		logic [4:0]         occupancy;
	} rsp_t;

	// Broadcast from the controller to every cell
	typedef struct packed {
		logic   update;  // commit this cycle
		logic   insert;  // 1 insert, 0 remove
		entry_t item;    // entry being inserted
	} cell_ctrl_t;

endpackage

// ----- hw/rtl/spq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry. On insert it keeps its entry, takes the new one, or takes
// its left neighbor's; on remove it takes its right neighbor's.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic               slot_valid,
	input  logic               prev_keep,
	input  spq_pkg::entry_t    prev_entry,
	input  spq_pkg::entry_t    next_entry,
	output logic               keep,
	output spq_pkg::entry_t    entry_q
);
	import spq_pkg::*;

	entry_t entry_d;

	// Entry stays in place when it ranks at or before the new item
	assign keep = slot_valid && ($signed(entry_q.rank) <= $signed(ctrl.item.rank));

	// Next entry selection
	always_comb begin
		if (ctrl.insert) begin
			if (keep) begin
				entry_d = entry_q;
			end else if (prev_keep) begin
				entry_d = ctrl.item;
			end else begin
				entry_d = prev_entry;
			end
		end else begin
			entry_d = next_entry;
		end
	end

	// Slot storage, payload only
	always_ff @(posedge clk) begin
		if (ctrl.update) begin
			entry_q <= entry_d;
		end
	end

endmodule

// ----- hw/rtl/sorted_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue kept in sorted order
// Chain of slot cells plus a fill counter and a registered response stage.
// ----------------------------------------------------------------------------
// For every command, all cells compare the new rank in parallel
// and shift left or right together, so a command is accepted in every cycle
// the response register is free or being drained, and its response appears
// on the next cycle. Lower rank leaves first; equal ranks leave in arrival
// order. Insert into a full queue is dropped with status overflow; remove
// from an empty queue returns status underflow with zero head fields. Every
// response carries the empty flag and occupancy after the command
// (occupancy is the low five bits of the fill count).
module sorted_priority_queue #(
	parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  spq_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output spq_pkg::rsp_t rsp
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] fill_d;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	rsp_t             rsp_d;
	logic             fire;
	logic             is_full;
	logic             is_emp;
	cell_ctrl_t       ctrl;

	logic   [QUEUE_DEPTH-1:0] slot_valid;
	logic   [QUEUE_DEPTH-1:0] keep;
	entry_t                   entry [QUEUE_DEPTH];

	// Handshake: response register frees up as it drains
	assign cmd_ready = !rsp_valid_q || rsp_ready;
	assign fire      = cmd_valid && cmd_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign is_full = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign is_emp  = (fill_q == '0);

	// Command decode and response build
	always_comb begin
		ctrl.insert     = (cmd.opcode == OP_INSERT);
		ctrl.item.value = cmd.value;
		ctrl.item.rank  = cmd.rank;
		ctrl.update     = 1'b0;
		fill_d          = fill_q;
		rsp_d.status     = ST_OK;
		rsp_d.head_value = '0;
		rsp_d.head_rank  = '0;
		if (ctrl.insert) begin
			if (is_full) begin
				rsp_d.status = ST_OVERFLOW;
			end else begin
				ctrl.update = fire;
				fill_d      = fill_q + 1'b1;
			end
		end else begin
			if (is_emp) begin
				rsp_d.status = ST_UNDERFLOW;
			end else begin
				ctrl.update      = fire;
				fill_d           = fill_q - 1'b1;
				rsp_d.head_value = entry[0].value;
				rsp_d.head_rank  = entry[0].rank;
			end
		end
		rsp_d.is_empty  = (fill_d == '0);
		rsp_d.occupancy = 5'(fill_d);
	end

	// Cell chain
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic   pk;
		entry_t pe;
		entry_t ne;

		assign slot_valid[i] = (CNT_W'(i) < fill_q);

		if (i == 0) begin : g_head
			assign pk = 1'b1;
			assign pe = '0;
		end else begin : g_body
			assign pk = keep[i-1];
			assign pe = entry[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign ne = '0;
		end else begin : g_mid
			assign ne = entry[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.slot_valid (slot_valid[i]),
			.prev_keep  (pk),
			.prev_entry (pe),
			.next_entry (ne),
			.keep       (keep[i]),
			.entry_q    (entry[i])
		);
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				fill_q      <= fill_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

endmodule
